>>> hdl/skdd_pkg.sv
// Shared types and constants for the SPH kernel density deposit core.
// Holds the fixed-point widths, the mode codes, the item and result records
// and the back-end state type. Depends on nothing.
`default_nettype none

package skdd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 24;
    localparam int CFG_W     = 9;
    localparam int IDX_W     = 24;
    localparam int DENS_W    = 32;
    localparam int DROP_W    = 7;
    localparam int BATCH_W   = 16;
    localparam int MODE_W    = 2;

    // Signed cell index along one axis, and distances from a cell centre.
    localparam int CELL_W  = POS_W - FRAC_BITS + 2;
    localparam int DIST_W  = FRAC_BITS + 3;
    localparam int SQ_W    = 2 * DIST_W - 2;
    localparam int SUM_W   = 2 * DIST_W;
    localparam int RT_W    = SUM_W / 2;
    localparam int REM_W   = RT_W + 3;
    localparam int U_W     = FRAC_BITS + 1;
    localparam int POLY_W  = FRAC_BITS + 3;
    localparam int PCALC_W = FRAC_BITS + 4;
    localparam int WT_W    = FRAC_BITS + 1;
    localparam int WPROD_W = POLY_W + 32;

    localparam logic [31:0]      INV_PI_Q32 = 32'd1367130551;
    localparam int               WT_SHIFT   = 34;
    localparam logic [RT_W-1:0]  ONE_X      = RT_W'(64'd1 << FRAC_BITS);
    localparam logic [RT_W-1:0]  TWO_X      = RT_W'(64'd2 << FRAC_BITS);
    localparam logic [POS_W-1:0] HALF_POS   = POS_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [FRAC_BITS-1:0] HALF_FR = FRAC_BITS'(64'd1 << (FRAC_BITS - 1));

    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_DEPOSIT = 2'd0,
        MODE_READ    = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [CELL_W-1:0] base_x;
        logic signed [CELL_W-1:0] base_y;
        logic signed [CELL_W-1:0] base_z;
        logic [POS_W-1:0]         pos_x;
        logic [POS_W-1:0]         pos_y;
        logic [POS_W-1:0]         pos_z;
        logic [IDX_W-1:0]         cell_index;
        logic [BATCH_W-1:0]       particles;
        logic                     done;
    } item_t;

    typedef struct packed {
        logic [DENS_W-1:0]  density_value;
        logic [DROP_W-1:0]  cells_dropped;
        logic               batch_done;
        logic [BATCH_W-1:0] particles_in_batch;
    } result_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_ACCESS,
        BK_WAIT,
        BK_FINISH
    } back_state_t;

endpackage

`default_nettype wire

>>> hdl/skdd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the density grid. Depends on nothing.
`default_nettype none

module skdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 262144
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/skdd_fifo.sv
// Small generic first-in first-out queue of fixed-width words.
// Used between front and back end and on the result side. Depends on nothing.
`default_nettype none

module skdd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  wdata,
    output logic             full,
    input  wire              pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = store[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hdl/skdd_front.sv
// Front end: accepts input transactions, rounds particle positions to the
// kernel base cells and keeps the batch count. Depends on skdd_pkg.
`default_nettype none

module skdd_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          push,
    output logic                         full,
    input  wire [skdd_pkg::MODE_W-1:0]   mode,
    input  wire [skdd_pkg::POS_W-1:0]    pos_x,
    input  wire [skdd_pkg::POS_W-1:0]    pos_y,
    input  wire [skdd_pkg::POS_W-1:0]    pos_z,
    input  wire [skdd_pkg::IDX_W-1:0]    cell_index,
    input  wire                          last_in_batch,
    input  wire                          q_full,
    input  wire                          clearing,
    output logic                         q_push,
    output skdd_pkg::item_t              q_item
);

    import skdd_pkg::*;

    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [BATCH_W-1:0] batch_inc;
    logic               accept;
    mode_t              mode_in;

    // Base cell is rint(p) - 1, rounding half to even.
    function automatic logic signed [CELL_W-1:0] base_cell(input logic [POS_W-1:0] p);
        logic [POS_W-FRAC_BITS-1:0] ip;
        logic [FRAC_BITS-1:0]       fr;
        logic                       up;
        ip = p[POS_W-1:FRAC_BITS];
        fr = p[FRAC_BITS-1:0];
        up = (fr > HALF_FR) || ((fr == HALF_FR) && ip[0]);
        return CELL_W'({2'b00, ip}) + CELL_W'(up) - CELL_W'(1);
    endfunction

    assign full    = q_full || clearing;
    assign accept  = push && !full;
    assign q_push  = accept;
    assign mode_in = mode_t'(mode);
    assign batch_inc = (batch_reg == '1) ? batch_reg : batch_reg + 1'b1;

    always_comb
    begin
        batch_next        = batch_reg;
        q_item.mode       = mode_in;
        q_item.base_x     = base_cell(pos_x);
        q_item.base_y     = base_cell(pos_y);
        q_item.base_z     = base_cell(pos_z);
        q_item.pos_x      = pos_x;
        q_item.pos_y      = pos_y;
        q_item.pos_z      = pos_z;
        q_item.cell_index = cell_index;
        q_item.particles  = batch_reg;
        q_item.done       = 1'b0;
        if (mode_in == MODE_DEPOSIT)
        begin
            q_item.particles = batch_inc;
            q_item.done      = last_in_batch;
            if (accept)
            begin
                batch_next = last_in_batch ? '0 : batch_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= '0;
        end
        else
        begin
            batch_reg <= batch_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/skdd_back.sv
// Back end: walks the 4x4x4 kernel cells of a deposit through a distance,
// square-root and kernel pipeline into a read-modify-write on the grid RAM,
// and serves cell reads and clears. Depends on skdd_pkg, skdd_ram.
`default_nettype none

module skdd_back #(
    parameter int AXIS_SIZE = 64,
    parameter int ACC_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire [skdd_pkg::CFG_W-1:0]    grid_x,
    input  wire [skdd_pkg::CFG_W-1:0]    grid_y,
    input  wire [skdd_pkg::CFG_W-1:0]    grid_z,
    input  skdd_pkg::item_t              item,
    input  wire                          q_empty,
    output logic                         q_pop,
    input  wire                          res_full,
    output logic                         res_push,
    output skdd_pkg::result_t            res,
    output logic                         clearing
);

    import skdd_pkg::*;

    localparam int DEPTH   = AXIS_SIZE * AXIS_SIZE * AXIS_SIZE;
    localparam int AW      = $clog2(DEPTH);
    localparam int AXB     = $clog2(AXIS_SIZE);
    localparam int DW_WIDE = CELL_W + FRAC_BITS + 1;
    localparam int ADDR_WIDE = AXB + 3 * CFG_W + 2;
    localparam int LAT     = RT_W + 10;
    localparam int DRN_W   = $clog2(LAT + 1);

    back_state_t state_reg, state_next;

    logic [AW-1:0]     clr_reg;
    logic [5:0]        cnt_reg;
    logic [DRN_W-1:0]  drain_reg;
    logic [DROP_W-1:0] drop_reg;
    logic [DENS_W-1:0] dens_reg;

    logic [CFG_W-1:0]    gx, gy, gz;
    logic [2*CFG_W-1:0]  gxy_reg;
    logic [3*CFG_W-1:0]  total_reg;
    logic                idx_ok;

    // RAM ports
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [ACC_WIDTH-1:0] ram_wdata, ram_rdata;

    logic issue, access, finish;

    function automatic logic [CFG_W-1:0] clamp(input logic [CFG_W-1:0] r);
        if (r == '0)
        begin
            return CFG_W'(1);
        end
        if (r > CFG_W'(AXIS_SIZE))
        begin
            return CFG_W'(AXIS_SIZE);
        end
        return r;
    endfunction

    function automatic logic signed [DIST_W-1:0] offset(
        input logic signed [CELL_W-1:0] c,
        input logic [POS_W-1:0]         p
    );
        logic signed [DW_WIDE-1:0] w;
        w = (DW_WIDE'(c) <<< FRAC_BITS) - DW_WIDE'(HALF_POS) - DW_WIDE'(p);
        return w[DIST_W-1:0];
    endfunction

    function automatic logic in_grid(
        input logic signed [CELL_W-1:0] c,
        input logic [CFG_W-1:0]         lim
    );
        return !c[CELL_W-1] && (CFG_W'(c[CELL_W-2:0]) < lim);
    endfunction

    assign gx = clamp(grid_x);
    assign gy = clamp(grid_y);
    assign gz = clamp(grid_z);
    assign idx_ok = (3*CFG_W)'(item.cell_index) < total_reg;

    always_ff @(posedge clk)
    begin
        gxy_reg   <= gx * gy;
        total_reg <= gxy_reg * (2*CFG_W)'(gz);
    end

    // ---------------- issue stage: one kernel cell a cycle ----------------
    logic signed [CELL_W-1:0] cx, cy, cz;
    logic                     c_in;

    assign cx   = item.base_x + CELL_W'(cnt_reg[1:0]);
    assign cy   = item.base_y + CELL_W'(cnt_reg[3:2]);
    assign cz   = item.base_z + CELL_W'(cnt_reg[5:4]);
    assign c_in = in_grid(cx, gx) && in_grid(cy, gy) && in_grid(cz, gz);

    // stage 1: distances
    logic                     s1_vld, s1_in;
    logic signed [DIST_W-1:0] s1_dx, s1_dy, s1_dz;
    logic [AXB-1:0]           s1_cx, s1_cy, s1_cz;

    // stage 2: squares and address products
    logic                   s2_vld, s2_in;
    logic [SQ_W-1:0]        s2_qx, s2_qy, s2_qz;
    logic [AXB-1:0]         s2_ax;
    logic [AXB+CFG_W-1:0]   s2_ay;
    logic [AXB+2*CFG_W-1:0] s2_az;

    logic signed [2*DIST_W-1:0] px, py, pz;
    assign px = s1_dx * s1_dx;
    assign py = s1_dy * s1_dy;
    assign pz = s1_dz * s1_dz;

    // stage 3: sum of squares and linear address
    logic             s3_vld, s3_in;
    logic [SUM_W-1:0] s3_sum;
    logic [AW-1:0]    s3_addr;
    logic [ADDR_WIDE-1:0] addr_wide;

    assign addr_wide = ADDR_WIDE'(s2_ax) + ADDR_WIDE'(s2_ay) + ADDR_WIDE'(s2_az);

    always_ff @(posedge clk)
    begin
        s1_dx <= offset(cx, item.pos_x);
        s1_dy <= offset(cy, item.pos_y);
        s1_dz <= offset(cz, item.pos_z);
        s1_in <= c_in;
        s1_cx <= cx[AXB-1:0];
        s1_cy <= cy[AXB-1:0];
        s1_cz <= cz[AXB-1:0];

        s2_qx <= px[SQ_W-1:0];
        s2_qy <= py[SQ_W-1:0];
        s2_qz <= pz[SQ_W-1:0];
        s2_in <= s1_in;
        s2_ax <= s1_cx;
        s2_ay <= s1_cy * gx;
        s2_az <= s1_cz * gxy_reg;

        s3_sum  <= SUM_W'(s2_qx) + SUM_W'(s2_qy) + SUM_W'(s2_qz);
        s3_in   <= s2_in;
        s3_addr <= addr_wide[AW-1:0];
    end

    // ---------------- square root: one result bit per stage ----------------
    logic [REM_W-1:0] rt_rem  [0:RT_W-1];
    logic [RT_W-1:0]  rt_root [0:RT_W-1];
    logic [SUM_W-1:0] rt_val  [0:RT_W-1];
    logic             rt_vld  [0:RT_W-1];
    logic             rt_in   [0:RT_W-1];
    logic [AW-1:0]    rt_addr [0:RT_W-1];

    for (genvar g = 0; g < RT_W; g++)
    begin : g_root
        logic [REM_W-1:0] rem_i, rem_sh, trial;
        logic [RT_W-1:0]  root_i;
        logic [SUM_W-1:0] val_i;
        logic             vld_i, in_i, ge;
        logic [AW-1:0]    addr_i;

        if (g == 0)
        begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign val_i  = s3_sum;
            assign vld_i  = s3_vld;
            assign in_i   = s3_in;
            assign addr_i = s3_addr;
        end
        else
        begin : g_next
            assign rem_i  = rt_rem[g-1];
            assign root_i = rt_root[g-1];
            assign val_i  = rt_val[g-1];
            assign vld_i  = rt_vld[g-1];
            assign in_i   = rt_in[g-1];
            assign addr_i = rt_addr[g-1];
        end

        assign rem_sh = {rem_i[REM_W-3:0], val_i[SUM_W-1 -: 2]};
        assign trial  = {(REM_W-RT_W-2)'(0), root_i, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            rt_rem[g]  <= ge ? rem_sh - trial : rem_sh;
            rt_root[g] <= {root_i[RT_W-2:0], ge};
            rt_val[g]  <= val_i << 2;
            rt_in[g]   <= in_i;
            rt_addr[g] <= addr_i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_vld[g] <= 1'b0;
            end
            else
            begin
                rt_vld[g] <= vld_i;
            end
        end
    end

    // ---------------- cubic-spline kernel ----------------
    logic [RT_W-1:0] x, tx;
    logic            x_near, x_far;
    logic [U_W-1:0]  u;
    logic [2*U_W-1:0] uu;

    assign x      = rt_root[RT_W-1];
    assign x_near = x < ONE_X;
    assign x_far  = x >= TWO_X;
    assign tx     = TWO_X - x;
    assign u      = x_near ? x[U_W-1:0] : tx[U_W-1:0];
    assign uu     = u * u;

    logic           k1_vld, k1_in, k1_near, k1_far;
    logic [U_W-1:0] k1_u, k1_u2;
    logic [AW-1:0]  k1_addr;

    logic [2*U_W-1:0] uuu;
    assign uuu = k1_u2 * k1_u;

    logic           k2_vld, k2_in, k2_near, k2_far;
    logic [U_W-1:0] k2_u2, k2_u3;
    logic [AW-1:0]  k2_addr;

    logic [PCALC_W-1:0] pcalc;
    assign pcalc = PCALC_W'(64'd4 << FRAC_BITS) + PCALC_W'(k2_u3) * PCALC_W'(3)
                 - PCALC_W'(k2_u2) * PCALC_W'(6);

    logic              k3_vld, k3_in;
    logic [POLY_W-1:0] k3_poly;
    logic [AW-1:0]     k3_addr;

    logic [WPROD_W-1:0] wprod;
    assign wprod = WPROD_W'(k3_poly) * WPROD_W'(INV_PI_Q32)
                 + WPROD_W'(64'd1 << (WT_SHIFT - 1));

    logic            k4_vld, k4_in;
    logic [WT_W-1:0] k4_w;
    logic [AW-1:0]   k4_addr;

    // memory read issued from k4, data and write in the cycle after
    logic            m1_vld;
    logic [WT_W-1:0] m1_w;
    logic [AW-1:0]   m1_addr;
    logic [ACC_WIDTH:0] acc_sum;

    assign acc_sum = {1'b0, ram_rdata} + (ACC_WIDTH+1)'(m1_w);

    always_ff @(posedge clk)
    begin
        k1_in   <= rt_in[RT_W-1];
        k1_near <= x_near;
        k1_far  <= x_far;
        k1_u    <= u;
        k1_u2   <= uu[FRAC_BITS +: U_W];
        k1_addr <= rt_addr[RT_W-1];

        k2_in   <= k1_in;
        k2_near <= k1_near;
        k2_far  <= k1_far;
        k2_u2   <= k1_u2;
        k2_u3   <= uuu[FRAC_BITS +: U_W];
        k2_addr <= k1_addr;

        k3_in   <= k2_in;
        k3_addr <= k2_addr;
        if (k2_far)
        begin
            k3_poly <= '0;
        end
        else if (k2_near)
        begin
            k3_poly <= pcalc[POLY_W-1:0];
        end
        else
        begin
            k3_poly <= POLY_W'(k2_u3);
        end

        k4_in   <= k3_in;
        k4_w    <= wprod[WT_SHIFT +: WT_W];
        k4_addr <= k3_addr;

        m1_w    <= k4_w;
        m1_addr <= k4_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld <= 1'b0;
            s2_vld <= 1'b0;
            s3_vld <= 1'b0;
            k1_vld <= 1'b0;
            k2_vld <= 1'b0;
            k3_vld <= 1'b0;
            k4_vld <= 1'b0;
            m1_vld <= 1'b0;
        end
        else
        begin
            s1_vld <= issue;
            s2_vld <= s1_vld;
            s3_vld <= s2_vld;
            k1_vld <= rt_vld[RT_W-1];
            k2_vld <= k1_vld;
            k3_vld <= k2_vld;
            k4_vld <= k3_vld;
            m1_vld <= k4_vld && k4_in;
        end
    end

    // ---------------- grid RAM ----------------
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = m1_addr;
        ram_wdata = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];
        ram_re    = k4_vld && k4_in;
        ram_raddr = k4_addr;
        if (state_reg == BK_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (m1_vld)
        begin
            ram_we = 1'b1;
        end
        else if (access && (item.mode == MODE_CLEAR) && idx_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = item.cell_index[AW-1:0];
            ram_wdata = '0;
        end
        if (access)
        begin
            ram_re    = 1'b1;
            ram_raddr = item.cell_index[AW-1:0];
        end
    end

    skdd_ram #(
        .WIDTH (ACC_WIDTH),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty && !res_full)
                begin
                    state_next = (item.mode == MODE_DEPOSIT) ? BK_ISSUE : BK_ACCESS;
                end
            end
            BK_ISSUE:
            begin
                if (cnt_reg == 6'd63)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_ACCESS: state_next = BK_WAIT;
            BK_WAIT:   state_next = BK_FINISH;
            BK_FINISH: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        issue    = 1'b0;
        access   = 1'b0;
        finish   = 1'b0;
        clearing = 1'b0;
        case (state_reg)
            BK_CLEAR:  clearing = 1'b1;
            BK_ISSUE:  issue    = 1'b1;
            BK_ACCESS: access   = 1'b1;
            BK_FINISH: finish   = 1'b1;
            default:   issue    = 1'b0;
        endcase
    end

    assign q_pop    = finish;
    assign res_push = finish;

    always_comb
    begin
        res.density_value      = '0;
        res.cells_dropped      = '0;
        res.batch_done         = 1'b0;
        res.particles_in_batch = item.particles;
        if (item.mode == MODE_DEPOSIT)
        begin
            res.cells_dropped = drop_reg;
            res.batch_done    = item.done;
        end
        else if ((item.mode == MODE_READ) && idx_ok)
        begin
            res.density_value = dens_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            drain_reg <= '0;
            drop_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == BK_IDLE)
            begin
                cnt_reg  <= '0;
                drop_reg <= '0;
            end
            if (issue)
            begin
                cnt_reg   <= cnt_reg + 1'b1;
                drain_reg <= DRN_W'(LAT);
                if (!c_in)
                begin
                    drop_reg <= drop_reg + 1'b1;
                end
            end
            if (state_reg == BK_DRAIN)
            begin
                drain_reg <= drain_reg - 1'b1;
            end
        end
    end

    // A stored sum wider than the output saturates on the way out.
    logic [63:0] rd64;
    assign rd64 = 64'(ram_rdata);

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_WAIT)
        begin
            dens_reg <= (rd64 > 64'hFFFF_FFFF) ? '1 : rd64[DENS_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hdl/sph_kernel_density_deposit_core.sv
// SPH cubic-spline density deposit core: top level with the configuration port.
// A deposit issues its 64 kernel cells, one kernel cell per cycle, into the grid
// RAM pipeline, then waits in a drain state for the root and kernel pipeline to empty
// before the finish state. A read, clear or unused-mode transaction passes through
// the access, wait and finish states in the back end.
// After reset the grid is swept to zero, all AXIS_SIZE^3 cells (262144 at default), with
// full held high; configuration registers reset to 64 and take writes throughout.
// Depends on skdd_pkg, skdd_front, skdd_fifo, skdd_back, skdd_ram.
`default_nettype none

module sph_kernel_density_deposit_core #(
    parameter int AXIS_SIZE = 64,
    parameter int ACC_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [3:0]                    paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  wire                          push,
    output logic                         full,
    input  wire [skdd_pkg::MODE_W-1:0]   mode,
    input  wire [skdd_pkg::POS_W-1:0]    pos_x,
    input  wire [skdd_pkg::POS_W-1:0]    pos_y,
    input  wire [skdd_pkg::POS_W-1:0]    pos_z,
    input  wire [skdd_pkg::IDX_W-1:0]    cell_index,
    input  wire                          last_in_batch,
    output logic                         empty,
    input  wire                          pop,
    output logic [skdd_pkg::DENS_W-1:0]  density_value,
    output logic [skdd_pkg::DROP_W-1:0]  cells_dropped,
    output logic                         batch_done,
    output logic [skdd_pkg::BATCH_W-1:0] particles_in_batch
);

    import skdd_pkg::*;

    logic [CFG_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic             cfg_wr;
    logic [1:0]       reg_idx;

    item_t   fe_item, be_item;
    result_t be_res, out_res;
    logic    fe_push, iq_full, iq_empty, be_pop;
    logic    res_push, rq_full, clearing;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_x_reg <= CFG_W'(64);
            grid_y_reg <= CFG_W'(64);
            grid_z_reg <= CFG_W'(64);
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_GRID_X: grid_x_reg <= pwdata[CFG_W-1:0];
                REG_GRID_Y: grid_y_reg <= pwdata[CFG_W-1:0];
                REG_GRID_Z: grid_z_reg <= pwdata[CFG_W-1:0];
                default:    grid_x_reg <= grid_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GRID_X: prdata = 32'(grid_x_reg);
            REG_GRID_Y: prdata = 32'(grid_y_reg);
            REG_GRID_Z: prdata = 32'(grid_z_reg);
            default:    prdata = '0;
        endcase
    end

    skdd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .mode          (mode),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .cell_index    (cell_index),
        .last_in_batch (last_in_batch),
        .q_full        (iq_full),
        .clearing      (clearing),
        .q_push        (fe_push),
        .q_item        (fe_item)
    );

    skdd_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (2)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wdata (fe_item),
        .full  (iq_full),
        .pop   (be_pop),
        .rdata (be_item),
        .empty (iq_empty)
    );

    skdd_back #(
        .AXIS_SIZE (AXIS_SIZE),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .grid_x   (grid_x_reg),
        .grid_y   (grid_y_reg),
        .grid_z   (grid_z_reg),
        .item     (be_item),
        .q_empty  (iq_empty),
        .q_pop    (be_pop),
        .res_full (rq_full),
        .res_push (res_push),
        .res      (be_res),
        .clearing (clearing)
    );

    skdd_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (be_res),
        .full  (rq_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign density_value      = out_res.density_value;
    assign cells_dropped      = out_res.cells_dropped;
    assign batch_done         = out_res.batch_done;
    assign particles_in_batch = out_res.particles_in_batch;

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for sph_kernel_density_deposit_core.
// A queue-fed driver, a result monitor and a behavioural density-grid predictor;
// depends on skdd_pkg and the core RTL only.
`default_nettype none

module tb;
    import skdd_pkg::*;

    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          AXIS        = 64;
    localparam logic [63:0] ONE_FX      = 64'd1 << 16;
    localparam logic [63:0] HALF_FX     = 64'd1 << 15;
    localparam logic [63:0] ACC_MAX     = 64'hFFFF_FFFF;

    typedef struct {
        mode_t       op;
        logic [23:0] px, py, pz, idx;
        logic        last;
    } particle_req_t;

    typedef struct {
        logic [31:0] dens;
        logic [6:0]  dropped;
        logic        done;
        logic [15:0] count;
    } deposit_res_t;

    logic        clk = 1'b0, rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready, push = 1'b0, full, empty, pop = 1'b0;
    logic [1:0]  mode = '0;
    logic [23:0] pos_x = '0, pos_y = '0, pos_z = '0, cell_index = '0;
    logic        last_in_batch = 1'b0;
    logic [31:0] density_value;
    logic [6:0]  cells_dropped;
    logic        batch_done;
    logic [15:0] particles_in_batch;

    sph_kernel_density_deposit_core dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    particle_req_t pending_reqs[$];
    deposit_res_t  expected_res[$];
    bit [31:0]     dens_grid[int unsigned];
    logic [15:0]   batch_cnt = '0;
    logic [8:0]    reg_gx = 9'd64, reg_gy = 9'd64, reg_gz = 9'd64;
    int            send_idle_pct = 0, pop_stall_pct = 0;
    int            errors = 0, cycles = 0;

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int clamp_axis(logic [8:0] r);
        if (r < 1) return 1;
        if (r > AXIS) return AXIS;
        return int'(r);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] spline_weight(logic [63:0] x);
        logic [63:0] x2, x3, t, poly;
        if (x < ONE_FX)
        begin
            x2 = (x * x) >> 16;
            x3 = (x2 * x) >> 16;
            poly = 4 * ONE_FX + 3 * x3 - 6 * x2;
        end
        else if (x < 2 * ONE_FX)
        begin
            t = 2 * ONE_FX - x;
            x2 = (t * t) >> 16;
            poly = (x2 * t) >> 16;
        end
        else
            return 0;
        return (poly * 64'd1367130551 + (64'd1 << 33)) >> 34;
    endfunction

    // Nearest cell with ties to even, minus one: the low corner of the 4x4x4 stencil.
    function automatic int stencil_base(logic [23:0] p);
        int ip;
        ip = int'(p >> 16);
        if (p[15:0] > 16'h8000 || (p[15:0] == 16'h8000 && ip[0])) ip++;
        return ip - 1;
    endfunction

    function automatic deposit_res_t predict_density(particle_req_t r);
        deposit_res_t o;
        int gx, gy, gz, c[3], b[3], lim[3];
        logic [23:0] p[3];
        longint d;
        logic [63:0] s, w, acc;
        int unsigned addr;
        gx = clamp_axis(reg_gx);
        gy = clamp_axis(reg_gy);
        gz = clamp_axis(reg_gz);
        o = '{default: '0};
        if (r.op == MODE_DEPOSIT)
        begin
            p = '{r.px, r.py, r.pz};
            lim = '{gx, gy, gz};
            foreach (p[a]) b[a] = stencil_base(p[a]);
            for (int k = 0; k < 4; k++)
                for (int j = 0; j < 4; j++)
                    for (int i = 0; i < 4; i++)
                    begin
                        c = '{b[0] + i, b[1] + j, b[2] + k};
                        if (c[0] < 0 || c[0] >= lim[0] || c[1] < 0 || c[1] >= lim[1]
                            || c[2] < 0 || c[2] >= lim[2])
                        begin
                            o.dropped++;
                            continue;
                        end
                        s = 0;
                        for (int a = 0; a < 3; a++)
                        begin
                            d = longint'(c[a]) * 65536 - 32768 - longint'(p[a]);
                            s += d * d;
                        end
                        w = spline_weight(int_sqrt(s));
                        addr = c[0] + c[1] * gx + c[2] * gx * gy;
                        acc = dens_grid.exists(addr) ? dens_grid[addr] : 0;
                        acc = (acc > ACC_MAX - w) ? ACC_MAX : acc + w;
                        dens_grid[addr] = acc[31:0];
                    end
            if (batch_cnt != 16'hFFFF) batch_cnt++;
            o.count = batch_cnt;
            if (r.last)
            begin
                o.done = 1'b1;
                batch_cnt = '0;
            end
        end
        else
        begin
            if (r.idx < gx * gy * gz)
            begin
                if (r.op == MODE_READ && dens_grid.exists(r.idx)) o.dens = dens_grid[r.idx];
                if (r.op == MODE_CLEAR) dens_grid[r.idx] = 0;
            end
            o.count = batch_cnt;
        end
        return o;
    endfunction

    // Driver: the transaction is taken at the edge where push is high and full is low.
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            expected_res.push_back(predict_density(pending_reqs.pop_front()));
        end
        if (rst_n && pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push          <= 1'b1;
            mode          <= pending_reqs[0].op;
            pos_x         <= pending_reqs[0].px;
            pos_y         <= pending_reqs[0].py;
            pos_z         <= pending_reqs[0].pz;
            cell_index    <= pending_reqs[0].idx;
            last_in_batch <= pending_reqs[0].last;
        end
        else
            push <= 1'b0;
    end

    always @(posedge clk)
    begin
        deposit_res_t w;
        if (pop && !empty)
        begin
            if (expected_res.size() == 0)
                report("unexpected result", density_value, 0);
            else
            begin
                w = expected_res.pop_front();
                if (density_value !== w.dens) report("density_value", density_value, w.dens);
                if (cells_dropped !== w.dropped)
                    report("cells_dropped", cells_dropped, w.dropped);
                if (batch_done !== w.done) report("batch_done", batch_done, w.done);
                if (particles_in_batch !== w.count)
                    report("particles_in_batch", particles_in_batch, w.count);
            end
        end
        pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_grid_reg(logic [1:0] which, logic [8:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {which, 2'b00}; pwdata <= {$urandom} & 32'hFFFF_FE00 | val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (which)
            REG_GRID_X: reg_gx = val;
            REG_GRID_Y: reg_gy = val;
            default:    reg_gz = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic add_req(mode_t op, logic [23:0] px, logic [23:0] py, logic [23:0] pz,
                           logic [23:0] idx, logic last);
        pending_reqs.push_back('{op, px, py, pz, idx, last});
    endtask

    // Position inside (or just around) an axis of g cells.
    function automatic logic [23:0] near_axis(int g);
        return 24'($urandom_range((g + 1) * 65536 - 1));
    endfunction

    task automatic random_batch(int n);
        int gx, gy, gz, sel;
        logic [23:0] idx;
        gx = clamp_axis(reg_gx);
        gy = clamp_axis(reg_gy);
        gz = clamp_axis(reg_gz);
        repeat (n)
        begin
            sel = $urandom_range(99);
            idx = 24'($urandom_range(gx * gy * gz - 1));
            if (sel < 55)
                add_req(MODE_DEPOSIT, near_axis(gx), near_axis(gy), near_axis(gz),
                        24'($urandom), $urandom_range(7) == 0);
            else if (sel < 80)
                add_req(MODE_READ, 24'($urandom), 24'($urandom), 24'($urandom), idx,
                        1'($urandom));
            else if (sel < 88)
                add_req(MODE_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom), idx,
                        1'($urandom));
            else if (sel < 93)
                add_req(MODE_DEPOSIT, 24'($urandom), 24'($urandom), 24'($urandom),
                        24'($urandom), 1'($urandom));
            else
                add_req(mode_t'($urandom_range(1, 3)), 24'($urandom), 24'($urandom),
                        24'($urandom), 24'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        logic [8:0] shapes[6][3];
        int idle_mix[4][2];
        shapes = '{'{9'd64, 9'd64, 9'd64}, '{9'd1, 9'd1, 9'd1}, '{9'd511, 9'd0, 9'd65},
                   '{9'd8, 9'd5, 9'd3}, '{9'd33, 9'd17, 9'd9}, '{9'd64, 9'd64, 9'd64}};
        idle_mix = '{'{0, 0}, '{77, 0}, '{0, 77}, '{35, 35}};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ties to even and odd, grid edges, every mode and a batch end.
        add_req(MODE_DEPOSIT, 24'h0A8000, 24'h0A8000, 24'h0A8000, 0, 1'b0);
        add_req(MODE_DEPOSIT, 24'h0B8000, 24'h0A0000, 24'h0A4000, 0, 1'b0);
        add_req(MODE_DEPOSIT, 24'h000000, 24'h000000, 24'h000000, 0, 1'b0);
        add_req(MODE_DEPOSIT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        add_req(MODE_DEPOSIT, 24'h3F8000, 24'h3FFFFF, 24'h400000, 0, 1'b0);
        add_req(MODE_DEPOSIT, 24'h010000, 24'h018000, 24'h00FFFF, 0, 1'b1);
        for (int i = 9; i < 13; i++)
            add_req(MODE_READ, 0, 0, 0, 24'(i + 10 * 64 + 10 * 4096), 1'b0);
        add_req(MODE_READ, 0, 0, 0, 24'd0, 1'b0);
        add_req(MODE_READ, 0, 0, 0, 24'd262143, 1'b0);
        add_req(MODE_READ, 0, 0, 0, 24'd262144, 1'b0);
        add_req(MODE_READ, 0, 0, 0, 24'hFFFFFF, 1'b1);
        add_req(MODE_CLEAR, 0, 0, 0, 24'(10 + 10 * 64 + 10 * 4096), 1'b0);
        add_req(MODE_READ, 0, 0, 0, 24'(10 + 10 * 64 + 10 * 4096), 1'b0);
        add_req(MODE_CLEAR, 0, 0, 0, 24'hFFFFFF, 1'b0);
        add_req(MODE_NONE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        add_req(MODE_DEPOSIT, 24'h200000, 24'h200000, 24'h200000, 0, 1'b1);
        add_req(MODE_READ, 0, 0, 0, 24'(32 + 32 * 64 + 32 * 4096), 1'b0);
        wait_drained();

        foreach (shapes[s])
        begin
            write_grid_reg(REG_GRID_X, shapes[s][0]);
            write_grid_reg(REG_GRID_Y, shapes[s][1]);
            write_grid_reg(REG_GRID_Z, shapes[s][2]);
            foreach (idle_mix[m])
            begin
                send_idle_pct = idle_mix[m][0];
                pop_stall_pct = idle_mix[m][1];
                random_batch(18);
                wait_drained();
            end
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
